// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PSA_ASSERT(lbl, prop, msg)
`define PSA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// psa_pkg
// Types, sizes and helpers of the priority scheduler with aging.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int LEVELS        = 4;
  localparam int QUEUE_DEPTH   = 256;
  localparam int PENDING_DEPTH = 256;

  localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVCW = $clog2(LEVELS + 1);
  localparam int QPW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PPW  = $clog2(PENDING_DEPTH);
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);
  localparam int LAW  = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int AW   = 26;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [1:0] CFG_AGE_OUT      = 2'd0;
  localparam logic [1:0] CFG_QUANTA_LIMIT = 2'd1;

  typedef logic [LVW-1:0] lvl_t;
  typedef logic [QPW-1:0] qptr_t;
  typedef logic [QCW-1:0] qcnt_t;
  typedef logic [PPW-1:0] pptr_t;
  typedef logic [PCW-1:0] pcnt_t;
  typedef logic [LAW-1:0] laddr_t;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAIN_RD, ST_DRAIN_CHK, ST_AGE_RD, ST_AGE_SUM, ST_AGE_CMP,
    ST_PUSH, ST_START, ST_END_SUM, ST_END_RND, ST_TA, ST_RS, ST_WT, ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0]  id;
    lvl_t        lvl;
    logic [23:0] arrive;
    logic [23:0] run;
  } job_t;

  typedef struct packed {
    job_t        job;
    logic [23:0] enq;
  } lentry_t;

  typedef struct packed {
    logic [23:0] age_out;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] quantum;
    logic        busy;
    logic [7:0]  owner;
    logic        fin_v;
    logic [7:0]  fin_id;
    logic        st_v;
    logic [2:0]  start_level;
    logic [16:0] end_q;
    logic [24:0] ta;
    logic [24:0] wt;
    logic [23:0] rs;
  } result_t;

  function automatic qptr_t qinc(qptr_t p);
    return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic pptr_t pinc(pptr_t p);
    return (p == PPW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic qptr_t qtail(qptr_t h, qcnt_t c);
    logic [QCW:0] s;
    s = (QCW+1)'(h) + (QCW+1)'(c);
    if (s >= (QCW+1)'(QUEUE_DEPTH)) s = s - (QCW+1)'(QUEUE_DEPTH);
    return s[QPW-1:0];
  endfunction

  function automatic pptr_t ptail(pptr_t h, pcnt_t c);
    logic [PCW:0] s;
    s = (PCW+1)'(h) + (PCW+1)'(c);
    if (s >= (PCW+1)'(PENDING_DEPTH)) s = s - (PCW+1)'(PENDING_DEPTH);
    return s[PPW-1:0];
  endfunction

  function automatic laddr_t laddr(lvl_t l, qptr_t p);
    return LAW'(l) * LAW'(QUEUE_DEPTH) + LAW'(p);
  endfunction

endpackage

// ----- rtl/psa_alu.sv -----
// ----------------------------------------------------------------------------
// psa_alu
// Shared add / subtract unit with borrow flag.
// ----------------------------------------------------------------------------
module psa_alu
  import psa_pkg::*;
(
  input  alu_op_t       op,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] y,
  output logic          borrow
);

  logic [AW:0] r;

  always_comb begin
    if (op == ALU_SUB) r = {1'b0, a} - {1'b0, b};
    else               r = {1'b0, a} + {1'b0, b};
  end

  assign y      = r[AW-1:0];
  assign borrow = (op == ALU_SUB) & r[AW];

endmodule

// ----- rtl/psa_core.sv -----
// ----------------------------------------------------------------------------
// psa_core
// Sequencer, queue memories and state of the scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_core
  import psa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_type,
  input  logic [7:0]  in_id,
  input  logic [2:0]  in_level,
  input  logic [23:0] in_arrive,
  input  logic [23:0] in_run,
  input  logic        res_free,
  output logic        res_push,
  output result_t     res
);

  state_t  state_r, state_nxt;
  logic [15:0] qcnt_r, qcnt_nxt, q_r, q_nxt;
  pptr_t   phead_r, phead_nxt;
  pcnt_t   pcnt_r, pcnt_nxt;
  qptr_t   lhead_r [LEVELS];
  qptr_t   lhead_nxt [LEVELS];
  qcnt_t   lcnt_r [LEVELS];
  qcnt_t   lcnt_nxt [LEVELS];
  logic    act_valid_r, act_valid_nxt;
  logic [7:0]  act_id_r, act_id_nxt;
  logic [16:0] act_end_r, act_end_nxt;
  job_t    cur_r, cur_nxt;
  logic [LVCW-1:0] lv_r, lv_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  lvl_t    sel_r, sel_nxt;
  result_t res_r, res_nxt;

  job_t    pend_mem [PENDING_DEPTH];
  lentry_t lvl_mem [LEVELS*QUEUE_DEPTH];
  job_t    pend_rdata_r;
  lentry_t lvl_rdata_r;
  logic    pend_we, pend_re, lvl_we, lvl_re;
  pptr_t   pend_wa;
  job_t    pend_wd;
  laddr_t  lvl_wa, lvl_ra;
  lentry_t lvl_wd;

  alu_op_t alu_op;
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic    alu_borrow;

  lvl_t    lidx, uidx, first_lv, in_lvl;
  logic    any_ne;
  logic [23:0] q8;

  psa_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  assign lidx = lv_r[LVW-1:0];
  assign uidx = lidx - 1'b1;
  assign q8   = {q_r, 8'h00};
  assign in_ready = (state_r == ST_IDLE);
  assign res_push = (state_r == ST_OUT) && res_free;
  assign res = res_r;

  always_comb begin
    if (in_level == 3'd0)                in_lvl = '0;
    else if (32'(in_level) > LEVELS)     in_lvl = LVW'(LEVELS - 1);
    else                                 in_lvl = LVW'(in_level - 3'd1);
  end

  always_comb begin
    any_ne   = 1'b0;
    first_lv = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lcnt_r[i] != '0) begin
        any_ne   = 1'b1;
        first_lv = LVW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    qcnt_nxt      = qcnt_r;
    q_nxt         = q_r;
    phead_nxt     = phead_r;
    pcnt_nxt      = pcnt_r;
    lhead_nxt     = lhead_r;
    lcnt_nxt      = lcnt_r;
    act_valid_nxt = act_valid_r;
    act_id_nxt    = act_id_r;
    act_end_nxt   = act_end_r;
    cur_nxt       = cur_r;
    lv_nxt        = lv_r;
    acc_nxt       = acc_r;
    sel_nxt       = sel_r;
    res_nxt       = res_r;
    pend_we       = 1'b0;
    pend_re       = 1'b0;
    pend_wa       = ptail(phead_r, pcnt_r);
    pend_wd       = '{id: in_id, lvl: in_lvl, arrive: in_arrive, run: in_run};
    lvl_we        = 1'b0;
    lvl_re        = 1'b0;
    lvl_wa        = '0;
    lvl_wd        = '{job: cur_r, enq: cur_r.arrive};
    lvl_ra        = '0;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_type == REQ_ARRIVAL) begin
            if (pcnt_r != PCW'(PENDING_DEPTH)) begin
              pend_we  = 1'b1;
              pcnt_nxt = pcnt_r + 1'b1;
            end
          end else begin
            q_nxt = qcnt_r;
            if (qcnt_r != 16'hFFFF) qcnt_nxt = qcnt_r + 16'd1;
            res_nxt = '0;
            res_nxt.quantum = qcnt_r;
            if (act_valid_r) begin
              if (act_end_r < {1'b0, qcnt_r}) begin
                res_nxt.fin_v  = 1'b1;
                res_nxt.fin_id = act_id_r;
                act_valid_nxt  = 1'b0;
              end else begin
                res_nxt.busy  = 1'b1;
                res_nxt.owner = act_id_r;
              end
            end
            state_nxt = ST_DRAIN_RD;
          end
        end
      end
      ST_DRAIN_RD: begin
        if (pcnt_r == '0) state_nxt = ST_START;
        else begin
          pend_re   = 1'b1;
          state_nxt = ST_DRAIN_CHK;
        end
      end
      ST_DRAIN_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(pend_rdata_r.arrive);
        alu_b  = AW'(q8);
        if (alu_borrow) begin
          cur_nxt   = pend_rdata_r;
          phead_nxt = pinc(phead_r);
          pcnt_nxt  = pcnt_r - 1'b1;
          lv_nxt    = LVCW'(1);
          state_nxt = ST_AGE_RD;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_AGE_RD: begin
        if (lv_r == LVCW'(LEVELS)) state_nxt = ST_PUSH;
        else if (lcnt_r[lidx] != '0 && lcnt_r[uidx] != QCW'(QUEUE_DEPTH)) begin
          lvl_re    = 1'b1;
          lvl_ra    = laddr(lidx, lhead_r[lidx]);
          state_nxt = ST_AGE_SUM;
        end else begin
          lv_nxt = lv_r + 1'b1;
        end
      end
      ST_AGE_SUM: begin
        alu_a     = AW'(lvl_rdata_r.enq);
        alu_b     = AW'(cfg.age_out);
        acc_nxt   = alu_y;
        state_nxt = ST_AGE_CMP;
      end
      ST_AGE_CMP: begin
        alu_op    = ALU_SUB;
        alu_a     = acc_r;
        alu_b     = AW'(cur_r.arrive);
        state_nxt = ST_AGE_RD;
        if (alu_borrow) begin
          lvl_we          = 1'b1;
          lvl_wa          = laddr(uidx, qtail(lhead_r[uidx], lcnt_r[uidx]));
          lvl_wd          = '{job: lvl_rdata_r.job, enq: acc_r[23:0]};
          lcnt_nxt[uidx]  = lcnt_r[uidx] + 1'b1;
          lhead_nxt[lidx] = qinc(lhead_r[lidx]);
          lcnt_nxt[lidx]  = lcnt_r[lidx] - 1'b1;
        end else begin
          lv_nxt = lv_r + 1'b1;
        end
      end
      ST_PUSH: begin
        if (lcnt_r[cur_r.lvl] != QCW'(QUEUE_DEPTH)) begin
          lvl_we = 1'b1;
          lvl_wa = laddr(cur_r.lvl, qtail(lhead_r[cur_r.lvl], lcnt_r[cur_r.lvl]));
          lcnt_nxt[cur_r.lvl] = lcnt_r[cur_r.lvl] + 1'b1;
        end
        state_nxt = ST_DRAIN_RD;
      end
      ST_START: begin
        if (!act_valid_r && q_r < cfg.limit && any_ne) begin
          lvl_re              = 1'b1;
          lvl_ra              = laddr(first_lv, lhead_r[first_lv]);
          lhead_nxt[first_lv] = qinc(lhead_r[first_lv]);
          lcnt_nxt[first_lv]  = lcnt_r[first_lv] - 1'b1;
          sel_nxt             = first_lv;
          state_nxt           = ST_END_SUM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_END_SUM: begin
        alu_a     = AW'(q8);
        alu_b     = AW'(lvl_rdata_r.job.run);
        acc_nxt   = alu_y;
        state_nxt = ST_END_RND;
      end
      ST_END_RND: begin
        alu_a         = acc_r;
        alu_b         = AW'(255);
        res_nxt.end_q = alu_y[24:8];
        state_nxt     = ST_TA;
      end
      ST_TA: begin
        alu_op     = ALU_SUB;
        alu_a      = AW'({res_r.end_q, 8'h00});
        alu_b      = AW'(lvl_rdata_r.job.arrive);
        res_nxt.ta = alu_borrow ? '0 : alu_y[24:0];
        state_nxt  = ST_RS;
      end
      ST_RS: begin
        alu_op     = ALU_SUB;
        alu_a      = AW'(q8);
        alu_b      = AW'(lvl_rdata_r.job.arrive);
        res_nxt.rs = alu_borrow ? '0 : alu_y[23:0];
        state_nxt  = ST_WT;
      end
      ST_WT: begin
        alu_op              = ALU_SUB;
        alu_a               = AW'(res_r.ta);
        alu_b               = AW'(lvl_rdata_r.job.run);
        res_nxt.wt          = alu_borrow ? '0 : alu_y[24:0];
        res_nxt.busy        = 1'b1;
        res_nxt.owner       = lvl_rdata_r.job.id;
        res_nxt.st_v        = 1'b1;
        res_nxt.start_level = 3'(sel_r) + 3'd1;
        act_valid_nxt       = 1'b1;
        act_id_nxt          = lvl_rdata_r.job.id;
        act_end_nxt         = res_r.end_q;
        state_nxt           = ST_OUT;
      end
      ST_OUT: begin
        if (res_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qcnt_r      <= '0;
      phead_r     <= '0;
      pcnt_r      <= '0;
      act_valid_r <= 1'b0;
      act_id_r    <= '0;
      act_end_r   <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        lhead_r[i] <= '0;
        lcnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      qcnt_r      <= qcnt_nxt;
      phead_r     <= phead_nxt;
      pcnt_r      <= pcnt_nxt;
      act_valid_r <= act_valid_nxt;
      act_id_r    <= act_id_nxt;
      act_end_r   <= act_end_nxt;
      lhead_r     <= lhead_nxt;
      lcnt_r      <= lcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    cur_r <= cur_nxt;
    lv_r  <= lv_nxt;
    acc_r <= acc_nxt;
    sel_r <= sel_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_re) pend_rdata_r <= pend_mem[phead_r];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (lvl_re) lvl_rdata_r <= lvl_mem[lvl_ra];
  end

  `PSA_ASSERT(a_pcnt_bound, pcnt_r <= PCW'(PENDING_DEPTH), "pending count over depth")
  `PSA_ASSERT(a_tick_blocks, (in_valid && in_ready && in_type == REQ_TICK) |=> !in_ready, "tick not sequenced")
  `PSA_ASSERT(a_start_owns, (res_push && res.st_v) |-> (res.busy && act_valid_r), "started job not active")
  `PSA_ASSERT_NEVER(a_fin_busy, res_push && res.fin_v && res.busy && !res.st_v, "retired job still busy")

endmodule

// ----- rtl/priority_scheduler_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_unit
// Non-preemptive priority scheduler with aging, stream interface.
// ----------------------------------------------------------------------------
// channel  direction  payload
// in_      slave      request: tuser = req_type, tdata = job fields
// out_     master     one result per tick request
// cfg_     slave      register write: cfg_index, cfg_data
//
// Arrival request: written into the pending queue unless it is full. Tick request:
// drain the pending queue while its head has arrived, promoting aged jobs one level
// up before each drained job is pushed, then start the head of the highest nonempty
// level when the slot is free and under the quanta limit, via the shared add/sub unit.
// Synchronous active-low reset; queue memories need no clearing pass.
// An output register lets the next request in while a result waits.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_unit
  import psa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // job_id, job_level, arrive_at, run_length
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // quantum, slot_busy, slot_owner, finished_valid,
                                   // finished_id, started_valid, start_level,
                                   // end_quantum, turnaround, waiting, response
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  cfg_t    cfg_r;
  logic    out_tvalid_r;
  result_t out_r;
  logic    res_push, res_free;
  result_t res;

  assign cfg_ready = 1'b1;
  assign res_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_out <= 24'd1280;
      cfg_r.limit   <= 16'd100;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_AGE_OUT)      cfg_r.age_out <= cfg_data;
      if (cfg_index == CFG_QUANTA_LIMIT) cfg_r.limit   <= cfg_data[15:0];
    end
  end

  psa_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_type   (in_tuser),
    .in_id     (in_tdata[7:0]),
    .in_level  (in_tdata[10:8]),
    .in_arrive (in_tdata[34:11]),
    .in_run    (in_tdata[58:35]),
    .res_free  (res_free),
    .res_push  (res_push),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (res_push) out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_push) out_r <= res;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_r.rs, out_r.wt, out_r.ta, out_r.end_q,
                       out_r.start_level, out_r.st_v, out_r.fin_id, out_r.fin_v,
                       out_r.owner, out_r.busy, out_r.quantum};

endmodule
